/* rtl/core/fibcc_pkg.sv */
// Package for the flash image block CRC checker.
// Holds the CRC constants and byte-step functions, the framing phase type and
// the queue item and result structures. No dependencies.
package fibcc_pkg;

    localparam logic [31:0] FILE_CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] FILE_CRC_SEED = 32'hFFFF_FFFF;
    localparam logic [15:0] BLOCK_CRC_POLY = 16'h1021;
    localparam logic [15:0] BLOCK_CRC_SEED = 16'hFFFF;
    localparam logic [15:0] BLOCK_COUNT_MAX = 16'hFFFF;
    localparam logic [31:0] BYTE_TOTAL_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] HEADER_FIELD_LAST = 32'd3;
    localparam logic [31:0] CRC_FIELD_LAST = 32'd1;
    localparam int M_TDATA_W = 168;
    localparam int M_PAD_W = 5;

    typedef enum logic [3:0] {
        PH_ADDR = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_CRC  = 4'b1000
    } phase_t;

    typedef enum logic {
        EV_BLOCK   = 1'b0,
        EV_SUMMARY = 1'b1
    } event_t;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data_byte;
        logic        end_of_stream;
        logic [31:0] file_crc;
    } item_t;

    typedef struct packed {
        event_t      event_kind;
        logic [31:0] block_address;
        logic [31:0] block_length;
        logic        block_crc_ok;
        logic [15:0] received_block_crc;
        logic [31:0] file_crc;
        logic        file_crc_ok;
        logic        stream_truncated;
        logic [15:0] good_block_count;
        logic [31:0] good_byte_total;
        logic        last_of_run;
    } result_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ FILE_CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'd0};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ BLOCK_CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/fibcc_front.sv */
// Front end of the flash image block CRC checker.
// Accepts input transfers, runs the file CRC-32 and forwards meaningful items
// to the queue. Depends on fibcc_pkg.
module fibcc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte
    input  logic                s_tuser,   // has_byte
    input  logic                s_tlast,   // end_of_stream
    output logic                push_valid,
    input  logic                push_ready,
    output fibcc_pkg::item_t    push_item
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_byte;
    logic        accept;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;
    assign crc_byte = s_tuser ? fibcc_pkg::crc32_byte(crc_reg, s_tdata) : crc_reg;

    always_comb begin
        crc_next = crc_reg;
        if (accept) begin
            crc_next = s_tlast ? fibcc_pkg::FILE_CRC_SEED : crc_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= fibcc_pkg::FILE_CRC_SEED;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign push_valid              = s_tvalid && (s_tuser || s_tlast);
    assign push_item.has_byte      = s_tuser;
    assign push_item.data_byte     = s_tdata;
    assign push_item.end_of_stream = s_tlast;
    assign push_item.file_crc      = ~crc_byte;

endmodule

/* rtl/core/fibcc_queue.sv */
// Small register FIFO between the front and back ends of the checker.
// Depends on fibcc_pkg for the item type.
module fibcc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  fibcc_pkg::item_t    push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output fibcc_pkg::item_t    pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fibcc_pkg::item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/fibcc_back.sv */
// Back end of the flash image block CRC checker.
// Deframes blocks, runs the block CRC-16, keeps the good-block counters and
// drives the result register with a one-entry overflow stage. Depends on fibcc_pkg.
module fibcc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  fibcc_pkg::item_t    in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output fibcc_pkg::result_t  out_data
);

    fibcc_pkg::phase_t  phase_reg, phase_next, phase_mid;
    logic [31:0]        pos_reg, pos_next, pos_mid, pos_inc;
    logic [31:0]        addr_reg, addr_next;
    logic [31:0]        len_reg, len_next, len_shift;
    logic [15:0]        c16_reg, c16_next;
    logic [15:0]        rcv_reg, rcv_next, rcv_shift;
    logic [15:0]        gblk_reg, gblk_next;
    logic [31:0]        gbyt_reg, gbyt_next;
    logic [31:0]        expect_reg;
    logic [32:0]        byte_sum;
    logic               blk_done;
    logic               blk_ok;
    logic               pop;
    fibcc_pkg::result_t blk_res, sum_res;
    logic               out_valid_reg, out_valid_next;
    fibcc_pkg::result_t out_data_reg, out_data_next;
    logic               pend_valid_reg, pend_valid_next;
    fibcc_pkg::result_t pend_data_reg, pend_data_next;

    assign in_ready  = !pend_valid_reg && (!out_valid_reg || out_ready);
    assign pop       = in_valid && in_ready;
    assign pos_inc   = pos_reg + 32'd1;
    assign len_shift = {len_reg[23:0], in_item.data_byte};
    assign rcv_shift = {rcv_reg[7:0], in_item.data_byte};
    assign byte_sum  = {1'b0, gbyt_reg} + {1'b0, len_reg};

    always_comb begin
        phase_mid = phase_reg;
        pos_mid   = pos_reg;
        addr_next = addr_reg;
        len_next  = len_reg;
        c16_next  = c16_reg;
        rcv_next  = rcv_reg;
        gblk_next = gblk_reg;
        gbyt_next = gbyt_reg;
        blk_done  = 1'b0;
        blk_ok    = (rcv_shift == c16_reg);
        if (pop && in_item.has_byte) begin
            pos_mid = pos_inc;
            case (phase_reg)
                fibcc_pkg::PH_ADDR: begin
                    addr_next = {addr_reg[23:0], in_item.data_byte};
                    if (pos_reg == fibcc_pkg::HEADER_FIELD_LAST) begin
                        pos_mid   = '0;
                        phase_mid = fibcc_pkg::PH_LEN;
                    end
                end
                fibcc_pkg::PH_LEN: begin
                    len_next = len_shift;
                    if (pos_reg == fibcc_pkg::HEADER_FIELD_LAST) begin
                        pos_mid   = '0;
                        c16_next  = fibcc_pkg::BLOCK_CRC_SEED;
                        phase_mid = (len_shift == '0) ? fibcc_pkg::PH_CRC
                                                      : fibcc_pkg::PH_DATA;
                    end
                end
                fibcc_pkg::PH_DATA: begin
                    c16_next = fibcc_pkg::crc16_byte(c16_reg, in_item.data_byte);
                    if (pos_inc == len_reg) begin
                        pos_mid   = '0;
                        phase_mid = fibcc_pkg::PH_CRC;
                    end
                end
                fibcc_pkg::PH_CRC: begin
                    rcv_next = rcv_shift;
                    if (pos_reg == fibcc_pkg::CRC_FIELD_LAST) begin
                        blk_done = 1'b1;
                        if (blk_ok) begin
                            if (gblk_reg != fibcc_pkg::BLOCK_COUNT_MAX) begin
                                gblk_next = gblk_reg + 16'd1;
                            end
                            gbyt_next = byte_sum[32] ? fibcc_pkg::BYTE_TOTAL_MAX
                                                     : byte_sum[31:0];
                        end
                        phase_mid = fibcc_pkg::PH_ADDR;
                        pos_mid   = '0;
                        addr_next = '0;
                        len_next  = '0;
                        rcv_next  = '0;
                        c16_next  = fibcc_pkg::BLOCK_CRC_SEED;
                    end
                end
                default: begin
                    phase_mid = fibcc_pkg::PH_ADDR;
                    pos_mid   = '0;
                end
            endcase
        end

        blk_res                    = '0;
        blk_res.event_kind         = fibcc_pkg::EV_BLOCK;
        blk_res.block_address      = addr_reg;
        blk_res.block_length       = len_reg;
        blk_res.block_crc_ok       = blk_ok;
        blk_res.received_block_crc = rcv_shift;
        blk_res.good_block_count   = gblk_next;
        blk_res.good_byte_total    = gbyt_next;
        blk_res.last_of_run        = !in_item.end_of_stream;

        sum_res                  = '0;
        sum_res.event_kind       = fibcc_pkg::EV_SUMMARY;
        sum_res.file_crc         = in_item.file_crc;
        sum_res.file_crc_ok      = (in_item.file_crc == expect_reg);
        sum_res.stream_truncated = (phase_mid != fibcc_pkg::PH_ADDR) || (pos_mid != '0);
        sum_res.good_block_count = gblk_next;
        sum_res.good_byte_total  = gbyt_next;
        sum_res.last_of_run      = 1'b1;

        phase_next = phase_mid;
        pos_next   = pos_mid;
        if (pop && in_item.end_of_stream) begin
            phase_next = fibcc_pkg::PH_ADDR;
            pos_next   = '0;
            addr_next  = '0;
            len_next   = '0;
            rcv_next   = '0;
            c16_next   = fibcc_pkg::BLOCK_CRC_SEED;
            gblk_next  = '0;
            gbyt_next  = '0;
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (pend_valid_reg) begin
            if (out_ready) begin
                out_valid_next  = 1'b1;
                out_data_next   = pend_data_reg;
                pend_valid_next = 1'b0;
            end
        end else if (pop && (blk_done || in_item.end_of_stream)) begin
            out_valid_next = 1'b1;
            if (blk_done) begin
                out_data_next = blk_res;
                if (in_item.end_of_stream) begin
                    pend_valid_next = 1'b1;
                    pend_data_next  = sum_res;
                end
            end else begin
                out_data_next = sum_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= fibcc_pkg::PH_ADDR;
            pos_reg        <= '0;
            addr_reg       <= '0;
            len_reg        <= '0;
            c16_reg        <= fibcc_pkg::BLOCK_CRC_SEED;
            rcv_reg        <= '0;
            gblk_reg       <= '0;
            gbyt_reg       <= '0;
            expect_reg     <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            addr_reg       <= addr_next;
            len_reg        <= len_next;
            c16_reg        <= c16_next;
            rcv_reg        <= rcv_next;
            gblk_reg       <= gblk_next;
            gbyt_reg       <= gbyt_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid) begin
                expect_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        pend_data_reg <= pend_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/flash_image_block_crc_checker_top.sv */
// Top level of the flash image block CRC checker.
// Instantiates fibcc_front, fibcc_queue and fibcc_back; uses fibcc_pkg.
//
// The block takes one stream byte per transfer and sustains one input transfer
// per clock cycle while the queue has room. The front end runs the file CRC-32 (one
// unrolled byte step per cycle) and passes items through a QUEUE_DEPTH-entry queue
// to the back end, which deframes blocks and checks each block CRC-16 a byte at a
// time. An input that ends a block and also ends the stream gives two results,
// which leave back to back, block result first, while the output is ready; the queue
// absorbs the input side meanwhile. An input item is held in a queue slot, and its
// result in the output register, before the result is presented. The expected file
// CRC may be written on any cycle while the block is idle.
module flash_image_block_crc_checker_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,      // expected_file_crc
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // data_byte
    input  logic        s_tuser,       // has_byte
    input  logic        s_tlast,       // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // block_address, block_length, block_crc_ok, received_block_crc, file_crc,
    // file_crc_ok, stream_truncated, good_block_count, good_byte_total, zero pad
    output logic [fibcc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic        m_tuser,       // event_kind
    output logic        m_tlast        // last_of_run
);

    logic               q_push_valid;
    logic               q_push_ready;
    fibcc_pkg::item_t   q_push_item;
    logic               q_pop_valid;
    logic               q_pop_ready;
    fibcc_pkg::item_t   q_pop_item;
    fibcc_pkg::result_t res;

    assign cfg_ready = 1'b1;

    fibcc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item)
    );

    fibcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    fibcc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (q_pop_valid),
        .in_ready  (q_pop_ready),
        .in_item   (q_pop_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tuser = res.event_kind;
    assign m_tlast = res.last_of_run;
    assign m_tdata = {{fibcc_pkg::M_PAD_W{1'b0}}, res.good_byte_total, res.good_block_count,
                      res.stream_truncated, res.file_crc_ok, res.file_crc,
                      res.received_block_crc, res.block_crc_ok, res.block_length,
                      res.block_address};

    a_summary_is_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("summary result not marked as last of run");

    a_first_of_two_is_block : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tuser)
        else $error("non-final result is not a block event");

    a_back_stalls_on_output : assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop_valid && !q_pop_ready |-> m_tvalid)
        else $error("back end stalled with an empty output register");

    a_second_result_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser)
        else $error("summary did not follow a block event of the same input");

endmodule
